// ===== rtl/core/trnc_pkg.sv =====
// Shared types, constants and helpers of the token ring node controller.
// No dependencies; imported by every module of the block.
package trnc_pkg;

   localparam int POSITION_SLOTS_DEF  = 8;
   localparam int SENDER_SLOTS_DEF    = 5;
   localparam int MAX_FRAME_BYTES_DEF = 50;

   localparam int LEN_W = 6;
   localparam int IDX_W = 4;
   localparam int TOK_W = 16;

   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] EMPTY_POS = 8'd225;

   localparam logic [2:0]  NODE_ID_RST    = 3'd1;
   localparam logic [2:0]  NODE_COUNT_RST = 3'd5;
   localparam logic [15:0] RING_TO_RST    = 16'd1000;
   localparam logic [15:0] REPLY_TO_RST   = 16'd100;

   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_TX   = 2'd1,
      KIND_READ = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_LISTEN = 2'd0,
      PH_FRAME  = 2'd1,
      PH_AWAIT  = 2'd2,
      PH_REPLY  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CSR_NODE_ID    = 2'd0,
      CSR_NODE_COUNT = 2'd1,
      CSR_RING_TO    = 2'd2,
      CSR_REPLY_TO   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic do_byte;
      logic do_tick;
      logic do_write;
      logic do_read;
      logic do_end;
      logic do_pick;
      logic tx_start;
      logic tx_next;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   byte_end;
      logic   tick_send;
      logic   end_send;
      logic   out_free;
      logic   tx_final;
   } dp_status_type;

   typedef struct packed {
      logic [3:0] h;
      logic [3:0] t;
      logic [3:0] o;
   } dec_type;

   // Split a byte into decimal digits; tens by reciprocal multiply.
   function automatic dec_type dec_split(input logic [7:0] v);
      dec_type    r;
      logic [7:0] rem;
      logic [15:0] prod;
      logic [7:0] tens10;
      r.h    = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
      rem    = v - ((v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0));
      prod   = 16'(rem) * 16'd205;
      r.t    = 4'(prod >> 11);
      tens10 = 8'(r.t) * 8'd10;
      r.o    = 4'(rem - tens10);
      return r;
   endfunction

endpackage

// ===== rtl/core/token_ring_node_controller_unit.sv =====
// Token ring node controller: top level joining sequencer and datapath.
// Order: an accepted item is executed, then its single result is loaded into
// the result register; a byte that closes a frame passes a frame-end step first.
// An item that sends a frame instead picks the successor, then loads one frame byte
// per cycle while the result register is free (up to 37 bytes); the next item is taken
// once the last result is loaded, so items are handled one at a time.
// Reset (synchronous, active high) clears state at once; no clearing pass.
module token_ring_node_controller_unit #(
   parameter int POSITION_SLOTS  = trnc_pkg::POSITION_SLOTS_DEF,
   parameter int SENDER_SLOTS    = trnc_pkg::SENDER_SLOTS_DEF,
   parameter int MAX_FRAME_BYTES = trnc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // configuration writes, always taken
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic [2:0]  req_slot,
   input  logic [2:0]  req_sender_select,
   input  logic [7:0]  req_position_value,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [7:0]  rsp_read_value,
   output logic        rsp_startup_expired,
   output logic        rsp_last
);
   import trnc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   // registers accept a write in any cycle
   assign csr_ready = 1'b1;

   // sequencer: one item at a time, paces frame bytes into the result register
   trnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // datapath: parser, position stores, timers, frame generator, result register
   trnc_dp #(
      .POSITION_SLOTS  (POSITION_SLOTS),
      .SENDER_SLOTS    (SENDER_SLOTS),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_operation       (req_operation),
      .req_rx_byte         (req_rx_byte),
      .req_slot            (req_slot),
      .req_sender_select   (req_sender_select),
      .req_position_value  (req_position_value),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_read_value      (rsp_read_value),
      .rsp_startup_expired (rsp_startup_expired),
      .rsp_last            (rsp_last),
      .cmd                 (cmd),
      .st                  (st)
   );

endmodule

// ===== rtl/core/trnc_ctrl.sv =====
// Sequencer of the token ring node controller: accepts items, issues
// datapath commands and paces frame transmission. Depends on trnc_pkg.
module trnc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  trnc_pkg::dp_status_type st,
   output trnc_pkg::dp_cmd_type   cmd
);
   import trnc_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b00000001,
      S_EXEC    = 8'b00000010,
      S_END     = 8'b00000100,
      S_PICK    = 8'b00001000,
      S_TX_AT   = 8'b00010000,
      S_TX_BODY = 8'b00100000,
      S_RESP    = 8'b01000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (st.op)
               OP_BYTE: begin
                  cmd.do_byte = 1'b1;
                  state_in    = st.byte_end ? S_END : S_RESP;
               end
               OP_TICK: begin
                  cmd.do_tick = 1'b1;
                  state_in    = st.tick_send ? S_PICK : S_RESP;
               end
               OP_WRITE: begin
                  cmd.do_write = 1'b1;
                  state_in     = S_RESP;
               end
               default: begin
                  cmd.do_read = 1'b1;
                  state_in    = S_RESP;
               end
            endcase
         end
         S_END: begin
            cmd.do_end = 1'b1;
            state_in   = st.end_send ? S_PICK : S_RESP;
         end
         S_PICK: begin
            cmd.do_pick = 1'b1;
            state_in    = S_TX_AT;
         end
         S_TX_AT: begin
            if (st.out_free) begin
               cmd.tx_start = 1'b1;
               state_in     = S_TX_BODY;
            end
         end
         S_TX_BODY: begin
            if (st.out_free) begin
               cmd.tx_next = 1'b1;
               if (st.tx_final) state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (st.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_pick_then_tx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PICK) |=> (state_ff == S_TX_AT))
      else $error("pick not followed by frame start");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == S_EXEC))
      else $error("accepted item not executed");
   a_end_after_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END) |-> ($past(state_ff) == S_EXEC && $past(st.op) == OP_BYTE))
      else $error("frame end without byte");

endmodule

// ===== rtl/core/trnc_dp.sv =====
// Datapath of the token ring node controller: registers, frame parser,
// position stores, timers, frame byte generator and result register. Uses trnc_pkg.
module trnc_dp #(
   parameter int POSITION_SLOTS  = trnc_pkg::POSITION_SLOTS_DEF,
   parameter int SENDER_SLOTS    = trnc_pkg::SENDER_SLOTS_DEF,
   parameter int MAX_FRAME_BYTES = trnc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_data,
   input  logic [1:0]              req_operation,
   input  logic [7:0]              req_rx_byte,
   input  logic [2:0]              req_slot,
   input  logic [2:0]              req_sender_select,
   input  logic [7:0]              req_position_value,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_result_kind,
   output logic [7:0]              rsp_tx_byte,
   output logic [7:0]              rsp_read_value,
   output logic                    rsp_startup_expired,
   output logic                    rsp_last,
   input  trnc_pkg::dp_cmd_type    cmd,
   output trnc_pkg::dp_status_type st
);
   import trnc_pkg::*;

   localparam int MEM_DEPTH = SENDER_SLOTS * POSITION_SLOTS;
   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int OW = (POSITION_SLOTS > 1) ? $clog2(POSITION_SLOTS) : 1;
   localparam int EW = $clog2(POSITION_SLOTS + 2);

   // configuration
   logic [2:0]  node_id_ff, node_count_ff;
   logic [15:0] ring_to_ff, reply_to_ff;
   // latched item
   op_type      op_ff;
   logic [7:0]  rx_ff, val_ff;
   logic [2:0]  slot_ff, sel_ff;
   // ring state
   phase_type   phase_ff;
   logic [2:0]  successor_ff;
   logic [IDX_W-1:0] tidx_ff;
   logic [TOK_W-1:0] acc_ff, sender_ff, fsucc_ff;
   logic [LEN_W-1:0] len_ff;
   logic [15:0] ring_cd_ff, reply_cd_ff;
   logic        startup_ff;
   logic [7:0]  own_ff [POSITION_SLOTS];
   logic [7:0]  mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] filled_ff;
   logic [7:0]  rd_data_ff;
   logic        rd_ok_ff, rd_fill_ff;
   // frame generator
   logic [EW-1:0] e_ff;
   logic [1:0]  d_ff;
   // result register
   logic        out_valid_ff;
   logic [1:0]  out_kind_ff;
   logic [7:0]  out_tx_ff, out_rd_ff;
   logic        out_start_ff, out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff    <= NODE_ID_RST;
         node_count_ff <= NODE_COUNT_RST;
         ring_to_ff    <= RING_TO_RST;
         reply_to_ff   <= REPLY_TO_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NODE_ID:    node_id_ff    <= csr_data[2:0];
            CSR_NODE_COUNT: node_count_ff <= csr_data[2:0];
            CSR_RING_TO:    ring_to_ff    <= csr_data;
            default:        reply_to_ff   <= csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= op_type'(req_operation);
         rx_ff   <= req_rx_byte;
         slot_ff <= req_slot;
         sel_ff  <= req_sender_select;
         val_ff  <= req_position_value;
      end
   end

   // parser decode
   logic             in_frame, is_digit, empty, named, fin_en, store_ok;
   logic [LEN_W-1:0] len_inc;
   logic [IDX_W-1:0] tidx_inc;
   logic [TOK_W-1:0] fsucc_after;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [2:0]       pick_s;

   always_comb begin
      in_frame    = (phase_ff == PH_FRAME) || (phase_ff == PH_REPLY);
      is_digit    = (rx_ff >= CH_ZERO) && (rx_ff <= CH_NINE);
      len_inc     = len_ff + LEN_W'(1);
      tidx_inc    = (tidx_ff < IDX_W'(15)) ? tidx_ff + IDX_W'(1) : tidx_ff;
      empty       = (len_ff == '0);
      fsucc_after = (tidx_ff == IDX_W'(1)) ? acc_ff : fsucc_ff;
      named       = !empty && (tidx_inc >= IDX_W'(2)) && (fsucc_after == TOK_W'(node_id_ff));
      fin_en      = (cmd.do_byte && in_frame && rx_ff == CH_HASH) || (cmd.do_end && !empty);
      store_ok    = (tidx_ff >= IDX_W'(2)) && (tidx_ff < IDX_W'(15)) &&
                    (int'(tidx_ff) - 2 < POSITION_SLOTS) &&
                    (sender_ff >= TOK_W'(1)) && (int'(sender_ff) <= SENDER_SLOTS);
      wr_addr     = AW'((int'(sender_ff) - 1) * POSITION_SLOTS + int'(tidx_ff) - 2);
      rd_addr     = AW'((int'(sel_ff) - 1) * POSITION_SLOTS + int'(slot_ff));
      // next successor: step round the ring, skip self
      pick_s = successor_ff + 3'd1;
      if (node_count_ff == 3'd2 || node_id_ff == node_count_ff) begin
         if (pick_s >= node_count_ff) pick_s = 3'd1;
      end else if (pick_s > node_count_ff) begin
         pick_s = 3'd1;
      end
      if (pick_s == node_id_ff) pick_s = pick_s + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LISTEN;
         successor_ff <= NODE_ID_RST;
         tidx_ff      <= '0;
         acc_ff       <= '0;
         sender_ff    <= '0;
         fsucc_ff     <= '0;
         len_ff       <= '0;
         ring_cd_ff   <= RING_TO_RST;
         reply_cd_ff  <= '0;
         startup_ff   <= 1'b0;
      end else begin
         if (cmd.do_pick) begin
            successor_ff <= pick_s;
            tidx_ff      <= '0;
            acc_ff       <= '0;
            sender_ff    <= '0;
            fsucc_ff     <= '0;
            len_ff       <= '0;
            reply_cd_ff  <= reply_to_ff;
            phase_ff     <= PH_AWAIT;
         end else if (cmd.do_byte) begin
            if (!in_frame) begin
               if (rx_ff == CH_AT) begin
                  tidx_ff   <= '0;
                  acc_ff    <= '0;
                  sender_ff <= '0;
                  fsucc_ff  <= '0;
                  len_ff    <= '0;
                  phase_ff  <= (phase_ff == PH_LISTEN) ? PH_FRAME : PH_REPLY;
               end
            end else if (rx_ff != CH_DOLLAR) begin
               len_ff <= len_inc;
               if (is_digit) begin
                  acc_ff <= (acc_ff << 3) + (acc_ff << 1) + TOK_W'(rx_ff - CH_ZERO);
               end
            end
         end else if (cmd.do_end) begin
            if (phase_ff == PH_FRAME) begin
               phase_ff <= PH_LISTEN;
               if (named) successor_ff <= node_id_ff;
            end else if (named || empty) begin
               if (named) successor_ff <= node_id_ff;
            end else begin
               phase_ff   <= PH_LISTEN;
               ring_cd_ff <= ring_to_ff;
            end
         end else if (cmd.do_tick) begin
            if (phase_ff == PH_LISTEN || phase_ff == PH_FRAME) begin
               if (ring_cd_ff > 16'd1) begin
                  ring_cd_ff <= ring_cd_ff - 16'd1;
               end else begin
                  ring_cd_ff <= '0;
                  startup_ff <= 1'b1;
               end
            end else if (reply_cd_ff > 16'd1) begin
               reply_cd_ff <= reply_cd_ff - 16'd1;
            end else begin
               reply_cd_ff <= '0;
            end
         end
         // close the current token
         if (fin_en) begin
            if (tidx_ff == IDX_W'(0)) sender_ff <= acc_ff;
            if (tidx_ff == IDX_W'(1)) fsucc_ff <= acc_ff;
            tidx_ff <= tidx_inc;
            acc_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (fin_en && store_ok) begin
         filled_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_en && store_ok) mem[wr_addr] <= acc_ff[7:0];
      if (cmd.do_read) begin
         rd_data_ff <= mem[rd_addr];
         rd_fill_ff <= filled_ff[rd_addr];
         rd_ok_ff   <= (int'(slot_ff) < POSITION_SLOTS) && (sel_ff >= 3'd1) &&
                       (int'(sel_ff) <= SENDER_SLOTS);
      end
   end

   // frame generator: element e, digit step d (3 = separator)
   logic [7:0]    ev, tx_b;
   logic [OW-1:0] own_idx;
   logic [1:0]    d_next;
   logic          sep, final_b;
   dec_type       dg;

   always_comb begin
      own_idx = OW'(e_ff - EW'(2));
      if (e_ff == EW'(0))      ev = 8'(node_id_ff);
      else if (e_ff == EW'(1)) ev = 8'(successor_ff);
      else                     ev = own_ff[own_idx];
      dg      = dec_split(ev);
      sep     = (d_ff == 2'd3);
      final_b = sep && (e_ff == EW'(POSITION_SLOTS + 1));
      d_next  = d_ff + 2'd1;
      tx_b    = CH_HASH;
      case (d_ff)
         2'd0: begin
            if (ev >= 8'd100) begin
               tx_b   = CH_ZERO + 8'(dg.h);
               d_next = 2'd1;
            end else if (ev >= 8'd10) begin
               tx_b   = CH_ZERO + 8'(dg.t);
               d_next = 2'd2;
            end else begin
               tx_b   = CH_ZERO + 8'(dg.o);
               d_next = 2'd3;
            end
         end
         2'd1: tx_b = CH_ZERO + 8'(dg.t);
         2'd2: tx_b = CH_ZERO + 8'(dg.o);
         default: begin
            tx_b   = final_b ? CH_DOLLAR : CH_HASH;
            d_next = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.tx_start) begin
         e_ff <= '0;
         d_ff <= 2'd0;
      end else if (cmd.tx_next) begin
         d_ff <= d_next;
         if (sep) e_ff <= e_ff + EW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POSITION_SLOTS; i++) own_ff[i] <= EMPTY_POS;
      end else begin
         for (int i = 0; i < POSITION_SLOTS; i++) begin
            if (cmd.do_write && int'(slot_ff) == i) own_ff[i] <= val_ff;
            if (cmd.tx_next && sep && e_ff >= EW'(2) && int'(own_idx) == i) begin
               own_ff[i] <= EMPTY_POS;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.tx_start || cmd.tx_next || cmd.rsp_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tx_start || cmd.tx_next) begin
         out_kind_ff  <= KIND_TX;
         out_tx_ff    <= cmd.tx_start ? CH_AT : tx_b;
         out_rd_ff    <= '0;
         out_start_ff <= startup_ff;
         out_last_ff  <= cmd.tx_next && final_b;
      end else if (cmd.rsp_load) begin
         out_kind_ff  <= (op_ff == OP_READ) ? KIND_READ : KIND_NONE;
         out_tx_ff    <= '0;
         out_rd_ff    <= (op_ff != OP_READ || !rd_ok_ff) ? 8'd0 :
                         (rd_fill_ff ? rd_data_ff : EMPTY_POS);
         out_start_ff <= startup_ff;
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_kind     = out_kind_ff;
   assign rsp_tx_byte         = out_tx_ff;
   assign rsp_read_value      = out_rd_ff;
   assign rsp_startup_expired = out_start_ff;
   assign rsp_last            = out_last_ff;

   always_comb begin
      st.op        = op_ff;
      st.byte_end  = in_frame && ((rx_ff == CH_DOLLAR) ||
                     (len_inc >= LEN_W'(MAX_FRAME_BYTES - 1)));
      st.tick_send = (phase_ff == PH_LISTEN || phase_ff == PH_FRAME) ?
                     (ring_cd_ff <= 16'd1) : (reply_cd_ff <= 16'd1);
      st.end_send  = (phase_ff == PH_FRAME) ? named : (named || empty);
      st.out_free  = !out_valid_ff || rsp_ready;
      st.tx_final  = final_b;
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.tx_start || cmd.tx_next || cmd.rsp_load) |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten");
   a_pick_await: assert property (@(posedge clock) disable iff (reset)
      cmd.do_pick |=> (phase_ff == PH_AWAIT))
      else $error("send did not enter reply wait");
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.tx_next && final_b) |=> (out_last_ff && out_tx_ff == CH_DOLLAR))
      else $error("frame end not marked last");

endmodule
